>>> hdl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// Word machine package
// Opcodes, status codes, default sizes and instruction decode helpers.
// ----------------------------------------------------------------------------
package wvm_pkg;

  localparam int MEM_WORDS_DEF   = 32768;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [15:0] LAST_OP  = 16'd21;
  localparam logic [14:0] LAST_REG = 15'd7;
  localparam logic [14:0] ADDR_MASK = 15'h7FFF;

  // Opcodes.
  localparam logic [4:0] OP_HALT = 5'd0;
  localparam logic [4:0] OP_SET  = 5'd1;
  localparam logic [4:0] OP_PUSH = 5'd2;
  localparam logic [4:0] OP_POP  = 5'd3;
  localparam logic [4:0] OP_EQ   = 5'd4;
  localparam logic [4:0] OP_GT   = 5'd5;
  localparam logic [4:0] OP_JMP  = 5'd6;
  localparam logic [4:0] OP_JT   = 5'd7;
  localparam logic [4:0] OP_JF   = 5'd8;
  localparam logic [4:0] OP_ADD  = 5'd9;
  localparam logic [4:0] OP_MULT = 5'd10;
  localparam logic [4:0] OP_MOD  = 5'd11;
  localparam logic [4:0] OP_AND  = 5'd12;
  localparam logic [4:0] OP_OR   = 5'd13;
  localparam logic [4:0] OP_NOT  = 5'd14;
  localparam logic [4:0] OP_RMEM = 5'd15;
  localparam logic [4:0] OP_WMEM = 5'd16;
  localparam logic [4:0] OP_CALL = 5'd17;
  localparam logic [4:0] OP_RET  = 5'd18;
  localparam logic [4:0] OP_OUT  = 5'd19;
  localparam logic [4:0] OP_IN   = 5'd20;
  localparam logic [4:0] OP_NOP  = 5'd21;

  // Result status codes.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_BADREG  = 3'd3;
  localparam logic [2:0] ST_STACK   = 3'd4;
  localparam logic [2:0] ST_MODZ    = 3'd5;
  localparam logic [2:0] ST_ILLEGAL = 3'd6;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  function automatic logic [1:0] arg_count(input logic [4:0] op);
    logic [1:0] n;
    unique case (op)
      OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:          n = 2'd2;
      OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:        n = 2'd1;
      OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR:   n = 2'd3;
      default:                                                n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic has_dest(input logic [4:0] op);
    logic h;
    unique case (op)
      OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR,
      OP_NOT, OP_RMEM, OP_IN: h = 1'b1;
      default:                h = 1'b0;
    endcase
    return h;
  endfunction

endpackage

>>> hdl/word_vm_instruction_core.sv
// ----------------------------------------------------------------------------
// Word machine instruction core
// Executes load and step items against main memory, registers and stack.
// ----------------------------------------------------------------------------
// The input channel carries one item: a load item (tuser 0) writes one word
// into main memory, a step item (tuser 1) runs the instruction at ip. Each
// item produces exactly one result item on the output channel with the
// status, the in and out character flags and the ip after the item.
// Main memory and the call stack are single-port arrays with registered
// read data, so every word fetched passes through S_FETCH and S_GOT. A load
// item offers its result in the cycle after it is taken. A step item fetches
// each word (opcode plus up to three operands) and then runs S_EXEC,
// followed by S_POP, S_RET, S_RMEM or S_MUL for pop, ret, rmem and mult:
// halt and illegal opcodes report straight from S_GOT, and mod adds a
// shift-subtract remainder unit (S_DIV). One item is in work at a time, and
// the next item can be taken in the cycle after the result has been taken.
// After reset the core clears all MEM_WORDS words of main memory one word a
// cycle, with in_tready low. A finished result waits in the output
// register while out_tready is low, and no new item is taken until then.
// ----------------------------------------------------------------------------
module word_vm_instruction_core #(
  parameter int MEM_WORDS   = wvm_pkg::MEM_WORDS_DEF,
  parameter int STACK_DEPTH = wvm_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_address[14:0], load_word[30:15], in_char[38:31], in_char_valid[39]
  input  logic [39:0] in_tdata,
  // kind[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], in_char_used[3], out_valid[4], out_char[12:5],
  // next_ip[27:13], zero[31:28]
  output logic [31:0] out_tdata
);
  import wvm_pkg::*;

  localparam int AW  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_GOT, S_EXEC, S_POP, S_RET, S_RMEM, S_MUL,
    S_DIV, S_RESP
  } state_t;

  state_t        state_r;
  logic [AW-1:0] clr_cnt_r;
  logic [14:0]   ip_r;
  logic [SPW-1:0] sp_r;
  logic [15:0]   regs_r [8];
  logic [1:0]    idx_r;
  logic [1:0]    n_r;
  logic [4:0]    op_r;
  logic [2:0]    d_r;
  logic          bad_r;
  logic [15:0]   v_r [3];
  logic [7:0]    char_r;
  logic          char_ok_r;
  logic [31:0]   prod_r;
  logic [15:0]   rem_r;
  logic [15:0]   dvd_r;
  logic [3:0]    cnt_r;
  logic          out_tvalid_r;
  logic [31:0]   out_tdata_r;

  // Single-port main memory.
  logic [15:0]   mem [MEM_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wd;
  logic [15:0]   mem_rd_r;

  // Single-port call stack.
  logic [15:0]    stk [STACK_DEPTH];
  logic           stk_we;
  logic [SIW-1:0] stk_addr;
  logic [15:0]    stk_wd;
  logic [15:0]    stk_rd_r;

  logic        in_acc;
  logic [14:0] nip;
  logic        stk_full;
  logic        stk_empty;
  logic [16:0] div_trial;
  logic [15:0] div_rem;

  // Outcome of the execute cycle.
  logic [2:0]  ex_status;
  logic        ex_used;
  logic        ex_ov;
  logic [7:0]  ex_och;
  logic [14:0] ex_ip;
  state_t      ex_state;

  // Reduce a 15-bit address modulo MEM_WORDS by restoring compare-subtract; exact for addresses below 32 * MEM_WORDS.
  function automatic logic [AW-1:0] wrap(input logic [14:0] a);
    logic [20:0] r;
    r = {6'd0, a};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (21'(MEM_WORDS) << k)) r = r - (21'(MEM_WORDS) << k);
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [31:0] pack(input logic [2:0] st, input logic used,
                                       input logic ov, input logic [7:0] oc,
                                       input logic [14:0] ip);
    return {4'd0, ip, oc, ov, used, st};
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign stk_full  = (sp_r == SPW'(STACK_DEPTH));
  assign stk_empty = (sp_r == '0);
  assign nip       = ip_r + 15'd1 + 15'(n_r);

  assign div_trial = {rem_r, dvd_r[15]};
  assign div_rem   = (div_trial >= {1'b0, v_r[2]}) ?
                     16'(div_trial - {1'b0, v_r[2]}) : div_trial[15:0];

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = v_r[1];
    mem_addr = wrap(15'(ip_r + 15'(idx_r)));
    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wd   = '0;
        mem_addr = clr_cnt_r;
      end
      S_IDLE: begin
        mem_we   = in_acc && (in_tuser == KIND_LOAD);
        mem_wd   = in_tdata[30:15];
        mem_addr = wrap(in_tdata[14:0]);
      end
      S_EXEC: begin
        mem_we   = (op_r == OP_WMEM) && !bad_r;
        mem_addr = (op_r == OP_WMEM) ? wrap(v_r[0][14:0]) : wrap(v_r[1][14:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    stk_we   = 1'b0;
    stk_addr = sp_r[SIW-1:0];
    stk_wd   = v_r[0];
    if (state_r == S_EXEC) begin
      unique case (op_r)
        OP_PUSH: stk_we = !stk_full && !bad_r;
        OP_CALL: begin
          stk_we = !stk_full && !bad_r;
          stk_wd = {1'b0, 15'(ip_r + 15'd2)};
        end
        OP_POP, OP_RET: stk_addr = SIW'(sp_r - SPW'(1));
        default: ;
      endcase
    end
  end

  always_comb begin
    ex_status = ST_DONE;
    ex_used   = 1'b0;
    ex_ov     = 1'b0;
    ex_och    = 8'd0;
    ex_ip     = nip;
    ex_state  = S_RESP;
    if (bad_r) begin
      ex_status = ST_BADREG;
      ex_ip     = ip_r;
    end else begin
      unique case (op_r)
        OP_PUSH, OP_CALL: begin
          if (stk_full) begin
            ex_status = ST_STACK;
            ex_ip     = ip_r;
          end else if (op_r == OP_CALL) begin
            ex_ip = v_r[0][14:0];
          end
        end
        OP_POP, OP_RET: begin
          if (stk_empty) begin
            ex_status = ST_STACK;
            ex_ip     = ip_r;
          end else begin
            ex_state = (op_r == OP_POP) ? S_POP : S_RET;
          end
        end
        OP_JMP: ex_ip = v_r[0][14:0];
        OP_JT, OP_JF: begin
          if ((v_r[0] != 16'd0) == (op_r == OP_JT)) ex_ip = v_r[1][14:0];
        end
        OP_MULT: ex_state = S_MUL;
        OP_MOD: begin
          if (v_r[2] == 16'd0) begin
            ex_status = ST_MODZ;
            ex_ip     = ip_r;
          end else begin
            ex_state = S_DIV;
          end
        end
        OP_RMEM: ex_state = S_RMEM;
        OP_OUT: begin
          ex_ov  = 1'b1;
          ex_och = v_r[0][7:0];
        end
        OP_IN: begin
          if (!char_ok_r) begin
            ex_status = ST_WAIT;
            ex_ip     = ip_r;
          end else begin
            ex_used = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_addr] <= stk_wd;
    stk_rd_r <= stk[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      ip_r         <= '0;
      sp_r         <= '0;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
      n_r          <= '0;
      bad_r        <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(MEM_WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            char_r    <= in_tdata[38:31];
            char_ok_r <= in_tdata[39];
            idx_r     <= '0;
            bad_r     <= 1'b0;
            v_r[0]    <= '0;
            v_r[1]    <= '0;
            v_r[2]    <= '0;
            if (in_tuser == KIND_LOAD) begin
              out_tdata_r  <= pack(ST_DONE, 1'b0, 1'b0, 8'd0, ip_r);
              out_tvalid_r <= 1'b1;
              state_r      <= S_RESP;
            end else begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: state_r <= S_GOT;
        S_GOT: begin
          if (idx_r == 2'd0) begin
            op_r <= mem_rd_r[4:0];
            n_r  <= arg_count(mem_rd_r[4:0]);
            if (mem_rd_r == 16'd0) begin
              out_tdata_r  <= pack(ST_HALT, 1'b0, 1'b0, 8'd0, ip_r);
              out_tvalid_r <= 1'b1;
              state_r      <= S_RESP;
            end else if (mem_rd_r > LAST_OP) begin
              out_tdata_r  <= pack(ST_ILLEGAL, 1'b0, 1'b0, 8'd0, ip_r);
              out_tvalid_r <= 1'b1;
              state_r      <= S_RESP;
            end else if (arg_count(mem_rd_r[4:0]) == 2'd0) begin
              state_r <= S_EXEC;
            end else begin
              idx_r   <= 2'd1;
              state_r <= S_FETCH;
            end
          end else begin
            if (idx_r == 2'd1 && has_dest(op_r)) begin
              d_r <= mem_rd_r[2:0];
              if (mem_rd_r[14:0] > LAST_REG) bad_r <= 1'b1;
            end else if (mem_rd_r[15]) begin
              if (mem_rd_r[14:0] > LAST_REG) bad_r <= 1'b1;
              else v_r[idx_r - 2'd1] <= regs_r[mem_rd_r[2:0]];
            end else begin
              v_r[idx_r - 2'd1] <= mem_rd_r;
            end
            if (idx_r == n_r) begin
              state_r <= S_EXEC;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_FETCH;
            end
          end
        end
        S_EXEC: begin
          out_tdata_r  <= pack(ex_status, ex_used, ex_ov, ex_och, ex_ip);
          out_tvalid_r <= (ex_state == S_RESP);
          state_r      <= ex_state;
          ip_r         <= ex_ip;
          if (!bad_r) begin
            unique case (op_r)
              OP_SET: regs_r[d_r] <= v_r[1];
              OP_PUSH, OP_CALL: begin
                if (!stk_full) sp_r <= sp_r + SPW'(1);
              end
              OP_POP, OP_RET: begin
                if (!stk_empty) sp_r <= sp_r - SPW'(1);
              end
              OP_EQ: regs_r[d_r] <= {15'd0, v_r[1] == v_r[2]};
              OP_GT: regs_r[d_r] <= {15'd0, v_r[1] > v_r[2]};
              OP_ADD: regs_r[d_r] <= {1'b0, 15'(v_r[1] + v_r[2])};
              OP_MULT: prod_r <= v_r[1] * v_r[2];
              OP_MOD: begin
                if (v_r[2] != 16'd0) begin
                  rem_r <= '0;
                  dvd_r <= v_r[1];
                  cnt_r <= '0;
                end
              end
              OP_AND: regs_r[d_r] <= v_r[1] & v_r[2];
              OP_OR:  regs_r[d_r] <= v_r[1] | v_r[2];
              OP_NOT: regs_r[d_r] <= v_r[1] ^ {1'b0, ADDR_MASK};
              OP_IN: begin
                if (char_ok_r) regs_r[d_r] <= {8'd0, char_r};
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          regs_r[d_r]  <= stk_rd_r;
          out_tvalid_r <= 1'b1;
          state_r      <= S_RESP;
        end
        S_RET: begin
          ip_r         <= stk_rd_r[14:0];
          out_tdata_r  <= pack(ST_DONE, 1'b0, 1'b0, 8'd0, stk_rd_r[14:0]);
          out_tvalid_r <= 1'b1;
          state_r      <= S_RESP;
        end
        S_RMEM: begin
          regs_r[d_r]  <= mem_rd_r;
          out_tvalid_r <= 1'b1;
          state_r      <= S_RESP;
        end
        S_MUL: begin
          regs_r[d_r]  <= {1'b0, prod_r[14:0]};
          out_tvalid_r <= 1'b1;
          state_r      <= S_RESP;
        end
        S_DIV: begin
          rem_r <= div_rem;
          dvd_r <= {dvd_r[14:0], 1'b0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            regs_r[d_r]  <= div_rem;
            out_tvalid_r <= 1'b1;
            state_r      <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is never on offer while a new item may be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid_r))
    else $error("result pending while idle");

  // The stack never holds more than its depth.
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer out of range");

  // An accepted item closes the input channel until its result is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while busy");

endmodule
